FILE: rtl/matrix_vector_multiply_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the matrix-vector multiply block
// Shared clocking and reset handling for concurrent checks.
// ----------------------------------------------------------------------------
`ifndef MATRIX_VECTOR_MULTIPLY_MACROS_SVH
`define MATRIX_VECTOR_MULTIPLY_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MVM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MVM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/mvm_pkg.sv
// ----------------------------------------------------------------------------
// mvm_pkg
// Types and constants shared by the matrix-vector multiply modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mvm_pkg;

  localparam int VALUE_WIDTH   = 16;
  localparam int SUM_WIDTH     = 48;
  localparam int ROW_WIDTH     = 8;
  localparam int DIM_REG_WIDTH = 9;
  localparam int APB_AW        = 3;
  localparam int APB_DW        = 32;

  typedef enum logic {
    KindVector = 1'b0,
    KindMatrix = 1'b1
  } mvm_kind_t;

  // Register index, taken from paddr[2].
  typedef enum logic {
    RegNumRows = 1'b0,
    RegNumCols = 1'b1
  } mvm_reg_t;

  typedef struct packed {
    mvm_kind_t                     kind;
    logic signed [VALUE_WIDTH-1:0] value;
  } mvm_item_t;

  typedef struct packed {
    logic [ROW_WIDTH-1:0]        row_index;
    logic signed [SUM_WIDTH-1:0] sum;
    logic                        last_row;
  } mvm_result_t;

  // Bookkeeping that travels down the pipeline with each beat.
  typedef struct packed {
    logic                 is_matrix;
    logic                 row_end;
    logic                 last_row;
    logic [ROW_WIDTH-1:0] row_index;
  } mvm_tag_t;

endpackage

`default_nettype wire

FILE: rtl/mvm_vec_store.sv
// ----------------------------------------------------------------------------
// mvm_vec_store
// Vector element memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mvm_vec_store #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int DW    = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/mvm_ctrl.sv
// ----------------------------------------------------------------------------
// mvm_ctrl
// Write pointer, column and row counters; tags each accepted beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mvm_ctrl #(
  parameter int MAX_DIM = 256,
  parameter int IDX_W   = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                accept,
  input  mvm_pkg::mvm_item_t                  item,
  input  logic [mvm_pkg::DIM_REG_WIDTH-1:0]   num_rows,
  input  logic [mvm_pkg::DIM_REG_WIDTH-1:0]   num_cols,
  output logic                                we,
  output logic [IDX_W-1:0]                    waddr,
  output logic [IDX_W-1:0]                    raddr,
  output mvm_pkg::mvm_tag_t                   tag
);

  import mvm_pkg::*;

  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int EW    = (DIM_W > DIM_REG_WIDTH) ? DIM_W : DIM_REG_WIDTH;

  logic [IDX_W-1:0] wp, wp_next;
  logic [IDX_W-1:0] col, col_next;
  logic [IDX_W-1:0] row, row_next;
  logic [EW-1:0]    rows_eff, cols_eff;
  logic [EW-1:0]    wp_inc, col_inc, row_inc;
  logic             col_end, last;
  logic [IDX_W+ROW_WIDTH-1:0] row_wide;

  function automatic logic [EW-1:0] eff_dim(input logic [DIM_REG_WIDTH-1:0] r);
    logic [EW-1:0] w;
    w = EW'(r);
    if (r == '0) begin
      return EW'(1);
    end else if (w > EW'(MAX_DIM)) begin
      return EW'(MAX_DIM);
    end
    return w;
  endfunction

  always_comb begin
    rows_eff = eff_dim(num_rows);
    cols_eff = eff_dim(num_cols);
    wp_inc   = EW'(wp) + EW'(1);
    col_inc  = EW'(col) + EW'(1);
    row_inc  = EW'(row) + EW'(1);
    col_end  = (col_inc >= cols_eff);
    last     = (row_inc >= rows_eff);
    row_wide = {{ROW_WIDTH{1'b0}}, row};

    wp_next  = wp;
    col_next = col;
    row_next = row;
    we       = 1'b0;
    if (accept) begin
      if (item.kind == KindVector) begin
        we       = 1'b1;
        wp_next  = (wp_inc >= cols_eff) ? '0 : wp_inc[IDX_W-1:0];
        col_next = '0;
        row_next = '0;
      end else begin
        col_next = col_end ? '0 : col_inc[IDX_W-1:0];
        if (col_end) begin
          row_next = last ? '0 : row_inc[IDX_W-1:0];
        end
      end
    end

    waddr         = wp;
    raddr         = col;
    tag.is_matrix = (item.kind == KindMatrix);
    tag.row_end   = col_end;
    tag.last_row  = last;
    tag.row_index = row_wide[ROW_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      col <= '0;
      row <= '0;
    end else begin
      wp  <= wp_next;
      col <= col_next;
      row <= row_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/mvm_mac.sv
// ----------------------------------------------------------------------------
// mvm_mac
// Operand, product and accumulate stages with the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "matrix_vector_multiply_macros.svh"

module mvm_mac (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                accept,
  input  mvm_pkg::mvm_tag_t                   tag_in,
  input  logic signed [mvm_pkg::VALUE_WIDTH-1:0] a_in,
  input  logic [mvm_pkg::VALUE_WIDTH-1:0]     b_rd,
  output logic                                advance,
  output logic                                result_valid,
  input  logic                                result_ready,
  output mvm_pkg::mvm_result_t                result
);

  import mvm_pkg::*;

  logic                            s1_valid;
  mvm_tag_t                        s1_tag;
  logic signed [VALUE_WIDTH-1:0]   s1_a;
  logic                            s2_valid;
  mvm_tag_t                        s2_tag;
  logic signed [2*VALUE_WIDTH-1:0] s2_prod;
  logic signed [SUM_WIDTH-1:0]     acc;
  logic signed [SUM_WIDTH-1:0]     sum;
  logic                            emit;

  always_comb begin
    sum     = acc + SUM_WIDTH'(s2_prod);
    emit    = s2_valid && s2_tag.is_matrix && s2_tag.row_end;
    // Only a row-ending beat needs the result register.
    advance = !(emit && result_valid && !result_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_tag  <= tag_in;
      s1_a    <= a_in;
      s2_tag  <= s1_tag;
      s2_prod <= s1_a * $signed(b_rd);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (s2_valid && advance) begin
      if (!s2_tag.is_matrix || s2_tag.row_end) begin
        acc <= '0;
      end else begin
        acc <= sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit && advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit && advance) begin
      result.row_index <= s2_tag.row_index;
      result.sum       <= sum;
      result.last_row  <= s2_tag.last_row;
    end
  end

  `MVM_ASSERT_NEXT(a_stall_holds_product, s2_valid && !advance,
                   s2_valid && $stable(s2_prod), "product stage moved during a stall")
  `MVM_ASSERT_NEXT(a_emit_loads_result, emit && advance,
                   result_valid, "row end did not load the result register")
  `MVM_ASSERT_NEXT(a_row_end_clears_acc, emit && advance,
                   acc == '0, "accumulator not cleared after a row end")

endmodule

`default_nettype wire

FILE: rtl/matrix_vector_multiply.sv
// ----------------------------------------------------------------------------
// matrix_vector_multiply
// Streaming Y = A*B in Q8.8 with full-precision Q32.16 row sums.
// ----------------------------------------------------------------------------
//  Channel   Signals                              Direction  Content
//  item      item_valid, item_ready, item         in         kind, value
//  result    result_valid, result_ready, result   out        row_index, sum, last_row
//  config    psel, penable, pwrite, paddr, ...     in/out     num_rows, num_cols
//
//  One beat is accepted per cycle while the pipeline is not stalled. A
//  row-ending matrix beat passes the operand stage, where its vector element
//  is read, then the product register, and is then added to the running sum
//  and loaded into the result register.
//  Input is stalled only while a row-ending beat sits in the product stage
//  and the result register still holds an untaken result.
//  Reset is synchronous; the vector memory needs no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module matrix_vector_multiply #(
  parameter int MAX_DIM = 256
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  output logic                         item_ready,
  input  mvm_pkg::mvm_item_t           item,
  output logic                         result_valid,
  input  logic                         result_ready,
  output mvm_pkg::mvm_result_t         result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mvm_pkg::APB_AW-1:0]   paddr,
  input  logic [mvm_pkg::APB_DW-1:0]   pwdata,
  output logic [mvm_pkg::APB_DW-1:0]   prdata,
  output logic                         pready
);

  import mvm_pkg::*;

  // Width of a vector memory address and of each counter.
  localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  logic [DIM_REG_WIDTH-1:0] num_rows;
  logic [DIM_REG_WIDTH-1:0] num_cols;
  mvm_reg_t                 reg_sel;
  logic                     cfg_write;

  logic                     advance;
  logic                     accept;
  logic                     we;
  logic [IDX_W-1:0]         waddr;
  logic [IDX_W-1:0]         raddr;
  logic [VALUE_WIDTH-1:0]   b_rd;
  mvm_tag_t                 tag;

  // The configuration port is always ready; the register index is the
  // word address, so every address maps onto one of the two registers.
  assign pready    = 1'b1;
  assign reg_sel   = mvm_reg_t'(paddr[2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows <= DIM_REG_WIDTH'(256);
      num_cols <= DIM_REG_WIDTH'(256);
    end else if (cfg_write) begin
      unique case (reg_sel)
        RegNumRows: num_rows <= pwdata[DIM_REG_WIDTH-1:0];
        RegNumCols: num_cols <= pwdata[DIM_REG_WIDTH-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      RegNumRows: prdata = APB_DW'(num_rows);
      RegNumCols: prdata = APB_DW'(num_cols);
      default:    prdata = '0;
    endcase
  end

  // A beat enters whenever the pipeline is free to move.
  assign item_ready = advance;
  assign accept     = item_valid && item_ready;

  mvm_ctrl #(
    .MAX_DIM (MAX_DIM),
    .IDX_W   (IDX_W)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .item     (item),
    .num_rows (num_rows),
    .num_cols (num_cols),
    .we       (we),
    .waddr    (waddr),
    .raddr    (raddr),
    .tag      (tag)
  );

  // The read is registered, so the vector element lines up with the
  // operand stage of the beat that addressed it.
  mvm_vec_store #(
    .DEPTH (MAX_DIM),
    .AW    (IDX_W),
    .DW    (VALUE_WIDTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (item.value),
    .re    (accept),
    .raddr (raddr),
    .rdata (b_rd)
  );

  mvm_mac u_mac (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .tag_in       (tag),
    .a_in         (item.value),
    .b_rd         (b_rd),
    .advance      (advance),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

`default_nettype wire
